>>> hw/rtl/assert_macros.svh
// Assertion helpers shared by the RTL; every check is sampled on clk and muted in reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition holds on every active clock edge.
`define ASSERT_ALWAYS(lbl, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Consequent holds on the same edge as the antecedent.
`define ASSERT_IMPLY(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Consequent holds on the next clock edge after the antecedent.
`define ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

>>> hw/rtl/mcma_pkg.sv
package mcma_pkg;

    localparam int CH_W       = 3;
    localparam int SAMPLE_W   = 7;
    localparam int CC_W       = 7;
    localparam int CC_REGS    = 6;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 7;
    localparam int SAMPLE_MAX = 127;

    localparam int WINDOW_DEFAULT   = 10;
    localparam int CHANNELS_DEFAULT = 6;

    typedef logic [CC_W-1:0] cc_t;

    localparam cc_t CC_RESET [CC_REGS] = '{
        CC_W'(20), CC_W'(21), CC_W'(26), CC_W'(27), CC_W'(28), CC_W'(29)
    };

endpackage

>>> hw/rtl/mcma_cfg.sv
module mcma_cfg
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_write,
    input  logic [mcma_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [mcma_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  logic [mcma_pkg::CH_W-1:0]        rd_channel,
    output logic [mcma_pkg::CC_W-1:0]        rd_cc
);
    import mcma_pkg::*;

    cc_t cc_reg [CC_REGS];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < CC_REGS; i++)
            begin
                cc_reg[i] <= CC_RESET[i];
            end
        end
        else if (cfg_write)
        begin
            for (int i = 0; i < CC_REGS; i++)
            begin
                if (cfg_index == CFG_IDX_W'(i))
                begin
                    cc_reg[i] <= cfg_data[CC_W-1:0];
                end
            end
        end
    end

    always_comb
    begin
        rd_cc = '0;
        for (int i = 0; i < CC_REGS; i++)
        begin
            if (rd_channel == CH_W'(i))
            begin
                rd_cc = cc_reg[i];
            end
        end
    end

endmodule

>>> hw/rtl/mcma_ring.sv
`include "assert_macros.svh"

module mcma_ring
#(
    parameter int DEPTH = mcma_pkg::CHANNELS_DEFAULT * mcma_pkg::WINDOW_DEFAULT,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
)
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              rd_en,
    input  logic [AW-1:0]                     rd_addr,
    output logic [mcma_pkg::SAMPLE_W-1:0]     rd_data,
    input  logic                              wr_en,
    input  logic [AW-1:0]                     wr_addr,
    input  logic [mcma_pkg::SAMPLE_W-1:0]     wr_data
);
    import mcma_pkg::*;

    logic [SAMPLE_W-1:0] mem [DEPTH];
    logic [DEPTH-1:0]    valid_reg;
    logic [SAMPLE_W-1:0] rd_data_reg;
    logic                rd_valid_reg;
    logic                bypass;

    assign bypass = rd_en && wr_en && (rd_addr == wr_addr);

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= bypass ? wr_data : mem[rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end
        else
        begin
            if (wr_en)
            begin
                valid_reg[wr_addr] <= 1'b1;
            end
            if (rd_en)
            begin
                rd_valid_reg <= bypass || valid_reg[rd_addr];
            end
        end
    end

    assign rd_data = rd_valid_reg ? rd_data_reg : '0;

    `ASSERT_NEXT(a_ring_bypass, bypass, rd_data == $past(wr_data), "ring bypass lost write")
    `ASSERT_NEXT(a_ring_mark, wr_en, valid_reg[$past(wr_addr)], "ring entry not marked")
    `ASSERT_IMPLY(a_ring_zero, !rd_valid_reg, rd_data == '0, "unwritten entry not zero")

endmodule

>>> hw/rtl/mcma_avg.sv
module mcma_avg
#(
    parameter int WINDOW = mcma_pkg::WINDOW_DEFAULT,
    parameter int SUM_W  = $clog2(WINDOW * mcma_pkg::SAMPLE_MAX + 1)
)
(
    input  logic [SUM_W-1:0]              sum,
    output logic [mcma_pkg::SAMPLE_W-1:0] avg
);
    import mcma_pkg::*;

    localparam int L     = $clog2(WINDOW);
    localparam int SHIFT = SUM_W + L;
    localparam int RECIP = ((1 << SHIFT) + WINDOW - 1) / WINDOW;
    localparam int M_W   = SHIFT + 1;
    localparam int P_W   = SUM_W + M_W;

    logic [P_W-1:0] prod;

    assign prod = P_W'(sum) * P_W'(RECIP);
    assign avg  = prod[SHIFT +: SAMPLE_W];

endmodule

>>> hw/rtl/multichannel_moving_average_cc.sv
// Channel  Direction  Handshake             Beat
// in       receive    in_valid / in_stall   channel, sample_value, freeze
// out      send       out_valid / out_stall out_channel, cc_number, cc_value
// cfg      receive    cfg_write             cfg_index, cfg_data
//
// One beat per cycle sustained while out_stall is low; stages one, two and three register each beat in turn.
// The ring read is registered at accept; stage two forms the new running sum and writes
// the ring, stage three divides by the window with a reciprocal multiply.
// Asynchronous active-low reset clears ring valid bits, positions and sums at once; no clearing pass.
// A stalled output lets the empty stages behind it keep filling before in_stall rises.
`include "assert_macros.svh"

module multichannel_moving_average_cc
#(
    parameter int WINDOW   = mcma_pkg::WINDOW_DEFAULT,
    parameter int CHANNELS = mcma_pkg::CHANNELS_DEFAULT
)
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    output logic                             in_stall,
    input  logic [mcma_pkg::CH_W-1:0]        channel,
    input  logic [mcma_pkg::SAMPLE_W-1:0]    sample_value,
    input  logic                             freeze,
    output logic                             out_valid,
    input  logic                             out_stall,
    output logic [mcma_pkg::CH_W-1:0]        out_channel,
    output logic [mcma_pkg::CC_W-1:0]        cc_number,
    output logic [mcma_pkg::SAMPLE_W-1:0]    cc_value,
    input  logic                             cfg_write,
    input  logic [mcma_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [mcma_pkg::CFG_DATA_W-1:0]  cfg_data
);
    import mcma_pkg::*;

    localparam int DEPTH   = CHANNELS * WINDOW;
    localparam int AW      = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW      = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int PW      = (WINDOW > 1) ? $clog2(WINDOW) : 1;
    localparam int SUM_MAX = WINDOW * SAMPLE_MAX;
    localparam int SUM_W   = $clog2(SUM_MAX + 1);

    localparam logic [PW-1:0] POS_LAST = PW'(WINDOW - 1);
    localparam logic [AW-1:0] WIN_A    = AW'(WINDOW);

    logic [PW-1:0]    pos_reg [CHANNELS];
    logic [SUM_W-1:0] sum_reg [CHANNELS];

    logic                s1_valid_reg;
    logic [CH_W-1:0]     s1_channel_reg;
    logic [SAMPLE_W-1:0] s1_sample_reg;
    logic [AW-1:0]       s1_addr_reg;
    logic [PW-1:0]       s1_pos_reg;

    logic                s2_valid_reg;
    logic [CH_W-1:0]     s2_channel_reg;
    logic [SAMPLE_W-1:0] s2_sample_reg;
    logic [SUM_W-1:0]    s2_sum_reg;

    logic                out_valid_reg;
    logic [CH_W-1:0]     out_channel_reg;
    logic [CC_W-1:0]     cc_number_reg;
    logic [SAMPLE_W-1:0] cc_value_reg;

    logic                en1, en2, en3;
    logic                accept, take;
    logic                ch_ok;
    logic [CW-1:0]       in_idx, s1_idx;
    logic [PW-1:0]       in_pos, pos_next;
    logic [AW-1:0]       rd_addr;
    logic [SAMPLE_W-1:0] old_sample;
    logic [SUM_W-1:0]    sum_next;
    logic                s1_move;
    logic [SAMPLE_W-1:0] avg;
    logic [CC_W-1:0]     cc_lookup;

    assign en3      = !out_valid_reg || !out_stall;
    assign en2      = !s2_valid_reg || en3;
    assign en1      = !s1_valid_reg || en2;
    assign in_stall = !en1;
    assign accept   = in_valid && en1;

    assign ch_ok    = int'(channel) < CHANNELS;
    assign take     = accept && !freeze && ch_ok;
    assign in_idx   = CW'(channel);
    assign in_pos   = pos_reg[in_idx];
    assign pos_next = (in_pos == POS_LAST) ? '0 : in_pos + PW'(1);
    assign rd_addr  = AW'(in_idx) * WIN_A + AW'(in_pos);

    assign s1_idx   = CW'(s1_channel_reg);
    assign s1_move  = s1_valid_reg && en2;
    assign sum_next = sum_reg[s1_idx] - SUM_W'(old_sample) + SUM_W'(s1_sample_reg);

    mcma_ring #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_ring (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_en   (en1),
        .rd_addr (rd_addr),
        .rd_data (old_sample),
        .wr_en   (s1_move),
        .wr_addr (s1_addr_reg),
        .wr_data (s1_sample_reg)
    );

    mcma_avg #(
        .WINDOW (WINDOW),
        .SUM_W  (SUM_W)
    ) u_avg (
        .sum (s2_sum_reg),
        .avg (avg)
    );

    mcma_cfg u_cfg (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_write  (cfg_write),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .rd_channel (s2_channel_reg),
        .rd_cc      (cc_lookup)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < CHANNELS; i++)
            begin
                pos_reg[i] <= '0;
                sum_reg[i] <= '0;
            end
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (take)
            begin
                pos_reg[in_idx] <= pos_next;
            end
            if (s1_move)
            begin
                sum_reg[s1_idx] <= sum_next;
            end
            if (en1)
            begin
                s1_valid_reg <= take;
            end
            if (en2)
            begin
                s2_valid_reg <= s1_valid_reg;
            end
            if (en3)
            begin
                out_valid_reg <= s2_valid_reg && (avg != s2_sample_reg);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            s1_channel_reg <= channel;
            s1_sample_reg  <= sample_value;
            s1_addr_reg    <= rd_addr;
            s1_pos_reg     <= in_pos;
        end
        if (s1_move)
        begin
            s2_channel_reg <= s1_channel_reg;
            s2_sample_reg  <= s1_sample_reg;
            s2_sum_reg     <= sum_next;
        end
        if (en3 && s2_valid_reg)
        begin
            out_channel_reg <= s2_channel_reg;
            cc_number_reg   <= cc_lookup;
            cc_value_reg    <= avg;
        end
    end

    assign out_valid   = out_valid_reg;
    assign out_channel = out_channel_reg;
    assign cc_number   = cc_number_reg;
    assign cc_value    = cc_value_reg;

    `ASSERT_IMPLY(a_sum_range, s1_valid_reg, int'(sum_next) <= SUM_MAX, "running sum out of range")
    `ASSERT_IMPLY(a_pos_range, s1_valid_reg, int'(s1_pos_reg) < WINDOW, "ring position out of range")
    `ASSERT_IMPLY(a_out_chan, out_valid_reg, int'(out_channel_reg) < CHANNELS, "bad channel out")
    `ASSERT_NEXT(a_out_src, !s2_valid_reg && en3, !out_valid_reg, "result without source beat")

endmodule
